### rtl/core/dmsa_pkg.sv
// Package: shared types and constants of the debounced multi-sensor alarm.
package dmsa_pkg;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 56;
   localparam int unsigned RspDataWidth = 56;

   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   // Register indexes, paddr[4:2]
   typedef enum logic [2:0] {
      REG_TEMP_LOW  = 3'd0,
      REG_TEMP_HIGH = 3'd1,
      REG_FLOW_HIGH = 3'd2,
      REG_COND_HIGH = 3'd3,
      REG_TURB_HIGH = 3'd4,
      REG_DEBOUNCE  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      CH_TEMP = 2'd0,
      CH_FLOW = 2'd1,
      CH_COND = 2'd2,
      CH_TURB = 2'd3
   } channel_type;

   // Packed MSB first, so temp_tenths lands in the lowest bits
   typedef struct packed {
      logic               turb_ok;
      logic [6:0]         turb_value;
      logic               cond_ok;
      logic [13:0]        cond_value;
      logic               flow_ok;
      logic [13:0]        flow_tenths;
      logic               temp_ok;
      logic signed [14:0] temp_tenths;
   } sample_type;

   typedef struct packed {
      logic signed [14:0] temp_low_tenths;
      logic signed [14:0] temp_high_tenths;
      logic [13:0]        flow_high_tenths;
      logic [13:0]        cond_high;
      logic [6:0]         turb_high;
      logic [7:0]         debounce_count;
   } config_type;

   // Threshold check of one sample set
   typedef struct packed {
      logic               raw_alarm;
      channel_type        channel;
      logic signed [14:0] reading;
      logic signed [14:0] limit;
   } eval_type;

   // Packed MSB first, so raw_alarm lands in bit 0
   typedef struct packed {
      logic signed [14:0] snap_limit;
      logic signed [14:0] snap_reading;
      channel_type        snap_channel;
      logic               snap_valid;
      logic               rising;
      logic               confirmed;
      logic [15:0]        hit_count;
      logic               raw_alarm;
   } result_type;

endpackage

### rtl/core/dmsa_eval.sv
// Threshold compare and first-alarming-channel pick for one sample set.
module dmsa_eval (
   input  dmsa_pkg::sample_type sample,
   input  dmsa_pkg::config_type cfg,
   output dmsa_pkg::eval_type   eval
);

   logic t_low;
   logic t_high;
   logic f_al;
   logic c_al;
   logic u_al;

   assign t_low  = sample.temp_ok && (sample.temp_tenths <= cfg.temp_low_tenths);
   assign t_high = sample.temp_ok && (sample.temp_tenths > cfg.temp_high_tenths);
   assign f_al   = sample.flow_ok && (sample.flow_tenths > cfg.flow_high_tenths);
   assign c_al   = sample.cond_ok && (sample.cond_value > cfg.cond_high);
   assign u_al   = sample.turb_ok && (sample.turb_value > cfg.turb_high);

   always_comb begin
      eval.raw_alarm = t_low || t_high || f_al || c_al || u_al;
      // Priority: temperature (low before high), flow, conductivity, turbidity
      priority if (t_low || t_high) begin
         eval.channel = dmsa_pkg::CH_TEMP;
         eval.reading = sample.temp_tenths;
         eval.limit   = t_low ? cfg.temp_low_tenths : cfg.temp_high_tenths;
      end else if (f_al) begin
         eval.channel = dmsa_pkg::CH_FLOW;
         eval.reading = {1'b0, sample.flow_tenths};
         eval.limit   = {1'b0, cfg.flow_high_tenths};
      end else if (c_al) begin
         eval.channel = dmsa_pkg::CH_COND;
         eval.reading = {1'b0, sample.cond_value};
         eval.limit   = {1'b0, cfg.cond_high};
      end else begin
         eval.channel = dmsa_pkg::CH_TURB;
         eval.reading = {8'd0, sample.turb_value};
         eval.limit   = {8'd0, cfg.turb_high};
      end
   end

endmodule

### rtl/core/debounced_multi_sensor_alarm.sv
// Top level: debounced multi-sensor alarm with stream ports and an APB-style register port.
//
// Each req word carries one sample set (temperature, flow, conductivity, turbidity, each
// with a reading-ok flag) and yields exactly one rsp word. A channel with its ok flag low
// never alarms. Temperature alarms at or below the low threshold or above the high one;
// the others alarm above their threshold. Consecutive alarming words are counted
// (saturating at 65535), a clean word clears the count, and when the count equals the
// debounce register the first alarming channel, its reading and the crossed threshold
// are latched as the snapshot, reported in every later word. Rate: one word per clock,
// sustained while rsp_tready stays high. A word accepted at a clock edge sits in the input
// register, goes through the threshold compare and counter update combinationally, and
// lands in the result register once that register is free, which raises rsp_tvalid.
// While a result waits the input register still takes one more word; with both full,
// req_tready drops until rsp_tready frees the result register.
// Write registers only while the block is idle; registers sit at byte address 4*index.
module debounced_multi_sensor_alarm (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, lowest bit up: temp_tenths[14:0], temp_ok, flow_tenths[13:0], flow_ok,
   // cond_value[13:0], cond_ok, turb_value[6:0], turb_ok, 2 zero bits
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // rsp_tdata, lowest bit up: raw_alarm, hit_count[15:0], confirmed, rising,
   // snap_valid, snap_channel[1:0], snap_reading[14:0], snap_limit[14:0], 4 zero bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   dmsa_pkg::config_type    cfg_ff;
   dmsa_pkg::config_type    cfg_in;
   dmsa_pkg::reg_index_type csr_index;
   logic                    csr_write;

   // Input register
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   dmsa_pkg::sample_type s1_data_ff;

   // Result register
   logic                 out_valid_ff;
   logic                 out_valid_in;
   dmsa_pkg::result_type out_ff;
   dmsa_pkg::result_type out_in;

   // Alarm state
   logic [15:0]           run_count_ff;
   logic [15:0]           run_count_in;
   logic                  trig_valid_ff;
   logic                  trig_valid_in;
   dmsa_pkg::channel_type trig_channel_ff;
   dmsa_pkg::channel_type trig_channel_in;
   logic signed [14:0]    trig_reading_ff;
   logic signed [14:0]    trig_reading_in;
   logic signed [14:0]    trig_limit_ff;
   logic signed [14:0]    trig_limit_in;

   dmsa_pkg::eval_type eval;
   logic               advance;
   logic               rising;
   logic               req_accept;

   //------------------------------------------------------------------
   // Register port
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = dmsa_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            dmsa_pkg::REG_TEMP_LOW:  cfg_in.temp_low_tenths  = csr_pwdata[14:0];
            dmsa_pkg::REG_TEMP_HIGH: cfg_in.temp_high_tenths = csr_pwdata[14:0];
            dmsa_pkg::REG_FLOW_HIGH: cfg_in.flow_high_tenths = csr_pwdata[13:0];
            dmsa_pkg::REG_COND_HIGH: cfg_in.cond_high        = csr_pwdata[13:0];
            dmsa_pkg::REG_TURB_HIGH: cfg_in.turb_high        = csr_pwdata[6:0];
            dmsa_pkg::REG_DEBOUNCE:  cfg_in.debounce_count   = csr_pwdata[7:0];
            default: ;  // drop writes to unused addresses
         endcase
      end
   end

   // Read back; signed thresholds come back sign-extended
   always_comb begin
      unique case (csr_index)
         dmsa_pkg::REG_TEMP_LOW:
            csr_prdata = {{17{cfg_ff.temp_low_tenths[14]}}, cfg_ff.temp_low_tenths};
         dmsa_pkg::REG_TEMP_HIGH:
            csr_prdata = {{17{cfg_ff.temp_high_tenths[14]}}, cfg_ff.temp_high_tenths};
         dmsa_pkg::REG_FLOW_HIGH: csr_prdata = {18'd0, cfg_ff.flow_high_tenths};
         dmsa_pkg::REG_COND_HIGH: csr_prdata = {18'd0, cfg_ff.cond_high};
         dmsa_pkg::REG_TURB_HIGH: csr_prdata = {25'd0, cfg_ff.turb_high};
         dmsa_pkg::REG_DEBOUNCE:  csr_prdata = {24'd0, cfg_ff.debounce_count};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_low_tenths  <= 15'sd0;
         cfg_ff.temp_high_tenths <= 15'sd400;
         cfg_ff.flow_high_tenths <= 14'd300;
         cfg_ff.cond_high        <= 14'd2000;
         cfg_ff.turb_high        <= 7'd50;
         cfg_ff.debounce_count   <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   //------------------------------------------------------------------
   // Handshake: the result register frees up when empty or being taken,
   // and the input register moves forward whenever it does.
   //------------------------------------------------------------------
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   //------------------------------------------------------------------
   // Evaluate the held word
   //------------------------------------------------------------------
   dmsa_eval u_eval (
      .sample (s1_data_ff),
      .cfg    (cfg_ff),
      .eval   (eval)
   );

   always_comb begin
      // Count up while alarming, hold at the top, clear on a clean word
      priority if (!eval.raw_alarm) begin
         run_count_in = 16'd0;
      end else if (run_count_ff == dmsa_pkg::CNT_MAX) begin
         run_count_in = run_count_ff;
      end else begin
         run_count_in = run_count_ff + 16'd1;
      end
   end

   assign rising = eval.raw_alarm && (run_count_in == {8'd0, cfg_ff.debounce_count});

   always_comb begin
      trig_valid_in   = trig_valid_ff;
      trig_channel_in = trig_channel_ff;
      trig_reading_in = trig_reading_ff;
      trig_limit_in   = trig_limit_ff;
      if (rising) begin
         // Latch the snapshot on the confirming word
         trig_valid_in   = 1'b1;
         trig_channel_in = eval.channel;
         trig_reading_in = eval.reading;
         trig_limit_in   = eval.limit;
      end
   end

   always_comb begin
      out_in.raw_alarm    = eval.raw_alarm;
      out_in.hit_count    = run_count_in;
      out_in.confirmed    = run_count_in >= {8'd0, cfg_ff.debounce_count};
      out_in.rising       = rising;
      out_in.snap_valid   = trig_valid_in;
      out_in.snap_channel = trig_channel_in;
      out_in.snap_reading = trig_reading_in;
      out_in.snap_limit   = trig_limit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         run_count_ff    <= 16'd0;
         trig_valid_ff   <= 1'b0;
         trig_channel_ff <= dmsa_pkg::CH_TEMP;
         trig_reading_ff <= 15'sd0;
         trig_limit_ff   <= 15'sd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            run_count_ff    <= run_count_in;
            trig_valid_ff   <= trig_valid_in;
            trig_channel_ff <= trig_channel_in;
            trig_reading_ff <= trig_reading_in;
            trig_limit_ff   <= trig_limit_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= dmsa_pkg::sample_type'(req_tdata[53:0]);
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff};

`ifndef ASSERT_OFF
   // A rising word is always confirmed and carries a valid snapshot
   a_rising_confirmed: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.rising) |-> (out_ff.confirmed && out_ff.snap_valid))
      else $error("rising word without confirmed snapshot");

   // A clean word reports a zero count, an alarming one a nonzero count
   a_count_matches_raw: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.raw_alarm == (out_ff.hit_count != 16'd0)))
      else $error("hit_count disagrees with raw_alarm");

   // A clean word clears the run counter
   a_clean_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && !eval.raw_alarm) |=> (run_count_ff == 16'd0))
      else $error("run counter not cleared by clean word");

   // A held word stays held while the result register is stalled
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("input word lost during stall");
`endif

endmodule
